// ===== hw/rtl/hesd_pkg.sv =====
// ----------------------------------------------------------------------------
// hesd_pkg
// Types, character codes and lookup tables shared by the entity decoder.
// ----------------------------------------------------------------------------
package hesd_pkg;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;

    localparam logic [20:0] SCALAR_MAX = 21'h10FFFF;
    localparam logic [20:0] SURR_LO    = 21'h00D800;
    localparam logic [20:0] SURR_HI    = 21'h00DFFF;

    localparam int NUM_NAMES = 6;

    // Names: amp, apos, gt, lt, nbsp, quot (lower case, padded with zero).
    localparam logic [7:0] NAME_CH [NUM_NAMES][4] = '{
        '{8'h61, 8'h6D, 8'h70, 8'h00},
        '{8'h61, 8'h70, 8'h6F, 8'h73},
        '{8'h67, 8'h74, 8'h00, 8'h00},
        '{8'h6C, 8'h74, 8'h00, 8'h00},
        '{8'h6E, 8'h62, 8'h73, 8'h70},
        '{8'h71, 8'h75, 8'h6F, 8'h74}
    };
    localparam logic [2:0] NAME_LEN [NUM_NAMES] = '{3'd3, 3'd4, 3'd2, 3'd2, 3'd4, 3'd4};
    localparam logic [7:0] NAME_OUT [NUM_NAMES] =
        '{8'h26, 8'h27, 8'h3E, 8'h3C, 8'h20, 8'h22};

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_PROC,
        S_UTF,
        S_FRD,
        S_FEM,
        S_FIN
    } t_state;

    typedef enum logic [2:0] {
        EM_BYTE,
        EM_NAMED,
        EM_AMP,
        EM_UTF,
        EM_FLUSH
    } t_emit_sel;

    typedef struct packed {
        logic      load_in;
        logic      rd_q;
        logic      start_cand;
        logic      append;
        logic      fail;
        logic      clr_cand;
        logic      utf_next;
        logic      rd_flush;
        logic      fin;
        logic      emit;
        t_emit_sel sel;
    } t_cmd;

    typedef struct packed {
        logic in_cand;
        logic b_amp;
        logic b_semi;
        logic num_ok;
        logic name_ok;
        logic full;
        logic q_empty;
        logic can_emit;
        logic can_fin;
        logic utf_last;
        logic flush_done;
        logic last;
        logic has_pend;
    } t_stat;

    // Returns {valid, value} for one digit character.
    function automatic logic [4:0] digit_val(input logic [7:0] c, input logic hex);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if (hex && c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, c[3:0] + 4'd9};
        end else if (hex && c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/hesd_if.sv =====
// ----------------------------------------------------------------------------
// hesd_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface hesd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface hesd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       run_end;
    logic       stream_end;

    modport source (output valid, output out_byte, output out_valid, output run_end,
                    output stream_end, input ready);
    modport sink   (input valid, input out_byte, input out_valid, input run_end,
                    input stream_end, output ready);
endinterface

// ===== hw/rtl/hesd_ctrl.sv =====
// ----------------------------------------------------------------------------
// hesd_ctrl
// Sequencer that walks the byte queue and drives the datapath commands.
// ----------------------------------------------------------------------------
module hesd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  hesd_pkg::t_stat i_stat,
    output hesd_pkg::t_cmd  o_cmd
);
    import hesd_pkg::*;

    t_state r_state, n_state;
    t_state s_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        // Where to go once the current byte is finished.
        if (!i_stat.q_empty) begin
            s_done = S_READ;
        end else if (i_stat.last && i_stat.has_pend) begin
            s_done = S_FRD;
        end else begin
            s_done = S_FIN;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.sel  = EM_BYTE;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_q = 1'b1;
                n_state    = S_PROC;
            end
            S_PROC: begin
                if (!i_stat.in_cand) begin
                    if (i_stat.b_amp) begin
                        o_cmd.start_cand = 1'b1;
                        // The ampersand is held from the next cycle on, so a
                        // final item must flush it.
                        if (!i_stat.q_empty) begin
                            n_state = S_READ;
                        end else if (i_stat.last) begin
                            n_state = S_FRD;
                        end else begin
                            n_state = S_FIN;
                        end
                    end else if (i_stat.can_emit) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.sel  = EM_BYTE;
                        n_state    = s_done;
                    end
                end else if (i_stat.b_semi && i_stat.num_ok) begin
                    o_cmd.clr_cand = 1'b1;
                    n_state        = S_UTF;
                end else if (i_stat.b_semi && i_stat.name_ok) begin
                    if (i_stat.can_emit) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.sel      = EM_NAMED;
                        o_cmd.clr_cand = 1'b1;
                        // Nothing stays held once the name is resolved.
                        n_state        = i_stat.q_empty ? S_FIN : S_READ;
                    end
                end else if (i_stat.b_semi || i_stat.full) begin
                    // The held bytes after the ampersand and this one are scanned again.
                    if (i_stat.can_emit) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.sel  = EM_AMP;
                        o_cmd.fail = 1'b1;
                        n_state    = S_READ;
                    end
                end else begin
                    o_cmd.append = 1'b1;
                    n_state      = s_done;
                end
            end
            S_UTF: begin
                if (i_stat.can_emit) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.sel      = EM_UTF;
                    o_cmd.utf_next = 1'b1;
                    if (i_stat.utf_last) begin
                        n_state = s_done;
                    end
                end
            end
            S_FRD: begin
                o_cmd.rd_flush = 1'b1;
                n_state        = S_FEM;
            end
            S_FEM: begin
                if (i_stat.can_emit) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = EM_FLUSH;
                    n_state    = i_stat.flush_done ? S_FIN : S_FRD;
                end
            end
            S_FIN: begin
                if (i_stat.can_fin) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_READ))
        else $error("accepted item did not start a queue read");
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |=> (r_state == S_IDLE))
        else $error("block did not return to idle after finishing an item");
    a_fail_rescan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fail |-> (o_cmd.emit && o_cmd.sel == EM_AMP))
        else $error("failed candidate without a literal ampersand");

endmodule

// ===== hw/rtl/hesd_dp.sv =====
// ----------------------------------------------------------------------------
// hesd_dp
// Byte ring buffer, candidate parser, UTF-8 encoder and result registers.
// ----------------------------------------------------------------------------
module hesd_dp #(
    parameter int MAX_ENTITY_LEN = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hesd_in_if.sink         i_in,
    hesd_out_if.source      o_out,
    input  hesd_pkg::t_cmd  i_cmd,
    output hesd_pkg::t_stat o_stat
);
    import hesd_pkg::*;

    localparam int AW    = $clog2(MAX_ENTITY_LEN + 2);
    localparam int DEPTH = 1 << AW;
    localparam logic [AW-1:0] HOLD = AW'(MAX_ENTITY_LEN + 1);

    // The ring holds the candidate from its ampersand on and the bytes still
    // waiting to be scanned; together they never exceed the depth.
    logic [7:0]    mem [DEPTH];
    logic [7:0]    r_rdata;
    logic [AW-1:0] r_head, r_tail, r_cs, r_count, r_fi, r_rd_addr;
    logic          r_in_cand, r_last;

    logic          r_num_ok, r_hex, r_hasd, r_big;
    logic [20:0]   r_v;
    logic [NUM_NAMES-1:0] r_alive;
    logic [1:0]    r_uidx;

    logic [7:0]    r_hold;
    logic          r_hold_v;
    logic          r_out_v;
    logic [7:0]    r_out_byte;
    logic          r_out_bv, r_out_re, r_out_se;

    logic          out_free;
    logic [7:0]    lc;
    logic [4:0]    dv;
    logic [24:0]   nv;
    logic [AW-1:0] bidx;
    logic [NUM_NAMES-1:0] name_hit;
    logic [7:0]    name_byte;
    logic [1:0]    ulen;
    logic [7:0]    ubyte;
    logic [7:0]    em_byte;
    logic [AW-1:0] rd_addr;

    assign out_free = !r_out_v || o_out.ready;
    assign lc       = (r_rdata >= 8'h41 && r_rdata <= 8'h5A) ? (r_rdata + 8'h20) : r_rdata;
    assign dv       = digit_val(r_rdata, r_hex);
    assign nv       = r_hex ? ({r_v, 4'b0} + {21'd0, dv[3:0]})
                            : ({1'b0, r_v, 3'b0} + {3'b0, r_v, 1'b0} + {21'd0, dv[3:0]});
    assign bidx     = r_count - AW'(1);

    always_comb begin
        name_byte = 8'h00;
        for (int k = 0; k < NUM_NAMES; k++) begin
            name_hit[k] = r_alive[k] && (bidx == AW'(NAME_LEN[k]));
            if (name_hit[k]) begin
                name_byte = NAME_OUT[k];
            end
        end
    end

    always_comb begin
        if (r_v <= 21'h7F) begin
            ulen = 2'd0;
        end else if (r_v <= 21'h7FF) begin
            ulen = 2'd1;
        end else if (r_v <= 21'hFFFF) begin
            ulen = 2'd2;
        end else begin
            ulen = 2'd3;
        end
        ubyte = {2'b10, r_v[5:0]};
        case ({ulen, r_uidx})
            4'b00_00: ubyte = r_v[7:0];
            4'b01_00: ubyte = {3'b110, r_v[10:6]};
            4'b10_00: ubyte = {4'b1110, r_v[15:12]};
            4'b10_01: ubyte = {2'b10, r_v[11:6]};
            4'b11_00: ubyte = {5'b11110, r_v[20:18]};
            4'b11_01: ubyte = {2'b10, r_v[17:12]};
            4'b11_10: ubyte = {2'b10, r_v[11:6]};
            default:  ubyte = {2'b10, r_v[5:0]};
        endcase
    end

    always_comb begin
        case (i_cmd.sel)
            EM_NAMED: em_byte = name_byte;
            EM_AMP:   em_byte = CH_AMP;
            EM_UTF:   em_byte = ubyte;
            default:  em_byte = r_rdata;
        endcase
    end

    assign rd_addr = i_cmd.rd_flush ? (r_cs + r_fi) : r_head;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            mem[r_tail] <= i_in.in_byte;
        end
        if (i_cmd.rd_q || i_cmd.rd_flush) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Queue pointers, candidate tracking and incremental parse state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_fi      <= '0;
            r_in_cand <= 1'b0;
            r_last    <= 1'b0;
            r_uidx    <= '0;
        end else begin
            if (i_cmd.load_in) begin
                r_tail <= r_tail + AW'(1);
                r_last <= i_in.in_last;
            end
            if (i_cmd.rd_q) begin
                r_head    <= r_head + AW'(1);
                r_rd_addr <= r_head;
            end
            if (i_cmd.rd_flush) begin
                r_fi <= r_fi + AW'(1);
            end
            if (i_cmd.start_cand) begin
                r_cs      <= r_rd_addr;
                r_count   <= AW'(1);
                r_in_cand <= 1'b1;
                r_num_ok  <= 1'b0;
                r_hex     <= 1'b0;
                r_hasd    <= 1'b0;
                r_big     <= 1'b0;
                r_v       <= '0;
                r_alive   <= '1;
            end
            if (i_cmd.append) begin
                r_count <= r_count + AW'(1);
                for (int k = 0; k < NUM_NAMES; k++) begin
                    r_alive[k] <= r_alive[k] && (bidx < AW'(NAME_LEN[k]))
                                  && (NAME_CH[k][bidx[1:0]] == lc);
                end
                if (r_count == AW'(1)) begin
                    r_num_ok <= (r_rdata == CH_HASH);
                end else if (r_count == AW'(2) &&
                             (r_rdata == CH_X_LO || r_rdata == CH_X_UP)) begin
                    r_hex <= 1'b1;
                end else if (dv[4]) begin
                    r_hasd <= 1'b1;
                    if (!r_big) begin
                        if (nv > {4'd0, SCALAR_MAX}) begin
                            r_big <= 1'b1;
                        end else begin
                            r_v <= nv[20:0];
                        end
                    end
                end else begin
                    r_num_ok <= 1'b0;
                end
            end
            if (i_cmd.clr_cand) begin
                r_in_cand <= 1'b0;
                r_count   <= '0;
                r_uidx    <= '0;
            end
            if (i_cmd.utf_next) begin
                r_uidx <= r_uidx + 2'd1;
            end
            if (i_cmd.fail) begin
                r_head    <= r_cs + AW'(1);
                r_in_cand <= 1'b0;
                r_count   <= '0;
            end
            if (i_cmd.fin) begin
                r_fi <= '0;
                if (r_last) begin
                    r_in_cand <= 1'b0;
                    r_count   <= '0;
                end
            end
        end
    end

    // One result is held back so the last one of an item can carry run_end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (r_out_v && o_out.ready) begin
                r_out_v <= 1'b0;
            end
            if (i_cmd.emit) begin
                if (r_hold_v) begin
                    r_out_v    <= 1'b1;
                    r_out_byte <= r_hold;
                    r_out_bv   <= 1'b1;
                    r_out_re   <= 1'b0;
                    r_out_se   <= 1'b0;
                end
                r_hold   <= em_byte;
                r_hold_v <= 1'b1;
            end
            if (i_cmd.fin) begin
                if (r_hold_v) begin
                    r_out_v    <= 1'b1;
                    r_out_byte <= r_hold;
                    r_out_bv   <= 1'b1;
                    r_out_re   <= 1'b1;
                    r_out_se   <= r_last;
                    r_hold_v   <= 1'b0;
                end else if (r_last) begin
                    r_out_v    <= 1'b1;
                    r_out_byte <= 8'h00;
                    r_out_bv   <= 1'b0;
                    r_out_re   <= 1'b1;
                    r_out_se   <= 1'b1;
                end
            end
        end
    end

    assign o_out.valid      = r_out_v;
    assign o_out.out_byte   = r_out_byte;
    assign o_out.out_valid  = r_out_bv;
    assign o_out.run_end    = r_out_re;
    assign o_out.stream_end = r_out_se;

    always_comb begin
        o_stat.in_cand    = r_in_cand;
        o_stat.b_amp      = (r_rdata == CH_AMP);
        o_stat.b_semi     = (r_rdata == CH_SEMI);
        o_stat.num_ok     = r_num_ok && r_hasd && !r_big && !(r_v >= SURR_LO && r_v <= SURR_HI);
        o_stat.name_ok    = |name_hit;
        o_stat.full       = (r_count >= HOLD);
        o_stat.q_empty    = (r_head == r_tail);
        o_stat.can_emit   = !r_hold_v || out_free;
        o_stat.can_fin    = out_free;
        o_stat.utf_last   = (r_uidx == ulen);
        o_stat.flush_done = (r_fi == r_count);
        o_stat.last       = r_last;
        o_stat.has_pend   = (r_count != '0);
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= HOLD)
        else $error("held candidate exceeds its limit");
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_cand |-> (r_count == '0))
        else $error("bytes held without an open candidate");
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_hold_v) |-> out_free)
        else $error("result pushed into an occupied output register");

endmodule

// ===== hw/rtl/html_entity_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// html_entity_stream_decoder
// HTML character reference decoder with UTF-8 output over valid/ready items.
// ----------------------------------------------------------------------------
// One input item is taken at a time. A plain byte passes through accept,
// queue read, decode and finish before the next ready; each byte scanned
// again after a failed candidate takes another queue read and decode, each
// UTF-8 byte of a numeric reference its own emit step, and each byte flushed
// at end of stream a flush read and a flush emit, through the byte ring and
// its registered read. A result is held one step inside so the last byte of
// an item carries run_end; output stalls only pause the sequencer.
module html_entity_stream_decoder #(
    parameter int MAX_ENTITY_LEN = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hesd_in_if.sink    i_in,
    hesd_out_if.source o_out
);
    import hesd_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    assign i_in.ready = in_ready;

    hesd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hesd_dp #(
        .MAX_ENTITY_LEN (MAX_ENTITY_LEN)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

endmodule
